// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/wma_pkg.sv =====
// Shared constants and types for the windowed moving average block.
package wma_pkg;

	localparam int WINDOW = 50;
	localparam int SMP_W  = 16;
	localparam int AVG_W  = 16;
	localparam int PTR_W  = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = SMP_W + $clog2(WINDOW);
	localparam int STEP_W = $clog2(SUM_W);

	typedef enum logic [1:0] {
		S_IDLE,
		S_UPDATE,
		S_DIV,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic update;
		logic div_step;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_last;
	} sts_t;

endpackage

// ===== src/wma_ram.sv =====
// Generic single-port RAM with registered read data.
module wma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write on we, register the read word on re
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/wma_ctrl.sv =====
// Controller state machine for the windowed moving average block.
`include "assert_macros.svh"
module wma_ctrl import wma_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	// Output register is free when empty or being drained this cycle
	assign slot_free = !out_valid_q || out_ready;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Set on a new result, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_CLK(a_load_into_free_slot, cmd.load_out |-> slot_free,
		"result loaded over an untaken beat")
	`ASSERT_CLK(a_accept_goes_update, (in_valid && in_ready) |=> (state_q == S_UPDATE),
		"accepted beat did not start the update")
	`ASSERT_CLK(a_div_last_finishes, (cmd.div_step && sts.div_last) |=> (state_q == S_FINISH),
		"divider end did not reach finish")

endmodule

// ===== src/wma_dp.sv =====
// Datapath: sample store, running sum, fill count and radix-2 divider.
`include "assert_macros.svh"
module wma_dp import wma_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [SMP_W-1:0] sample,
	output logic [AVG_W-1:0] average
);

	logic [SMP_W-1:0]  sample_q;
	logic [SMP_W-1:0]  old_smp;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  sum_d;
	logic [PTR_W-1:0]  wp_q;
	logic [CNT_W-1:0]  count_q;
	logic              full;
	logic [SUM_W-1:0]  dq_q;
	logic [CNT_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W:0]    trial;
	logic              take;
	logic [CNT_W:0]    trial_sub;
	logic [AVG_W-1:0]  avg_q;

	assign full = (count_q == CNT_W'(WINDOW));

	// Sample store: read the slot about to be overwritten, then write it
	wma_ram #(
		.WIDTH(SMP_W),
		.DEPTH(WINDOW)
	) u_store (
		.clk   (clk),
		.re    (cmd.capture),
		.we    (cmd.update),
		.addr  (wp_q),
		.wdata (sample_q),
		.rdata (old_smp)
	);

	// Latch the incoming sample
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample;
		end
	end

	// Drop the overwritten sample once the window is full
	assign sum_d = full ? (sum_q - SUM_W'(old_smp) + SUM_W'(sample_q))
		: (sum_q + SUM_W'(sample_q));

	// Advance sum, write pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			wp_q    <= '0;
			count_q <= '0;
		end else if (cmd.update) begin
			sum_q <= sum_d;
			if (wp_q == PTR_W'(WINDOW - 1)) begin
				wp_q <= '0;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
			if (!full) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Restoring division step: one quotient bit per cycle
	assign trial     = {rem_q, dq_q[SUM_W-1]};
	assign take      = (trial >= {1'b0, count_q});
	assign trial_sub = trial - {1'b0, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.update) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			dq_q  <= sum_d;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dq_q  <= {dq_q[SUM_W-2:0], take};
			rem_q <= take ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign sts.div_last = (step_q == STEP_W'(SUM_W - 1));

	// Hold the result for the output beat
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			avg_q <= dq_q[AVG_W-1:0];
		end
	end

	assign average = avg_q;

	`ASSERT_CLK(a_count_in_range, count_q <= CNT_W'(WINDOW),
		"fill count beyond window")
	`ASSERT_CLK(a_ptr_in_range, wp_q <= PTR_W'(WINDOW - 1),
		"write pointer beyond window")
	`ASSERT_CLK(a_rem_below_divisor, cmd.div_step |=> (rem_q < count_q),
		"divider remainder not below fill count")

endmodule

// ===== src/windowed_moving_average.sv =====
// Top level of the windowed moving average block.
// Each sample beat (unsigned Q8.8) goes into a circular store of WINDOW entries
// and produces one average beat: the truncated mean of the samples written so far
// until the store first fills, then of the last WINDOW samples. The slot being
// overwritten is read at the accepting edge, then the running sum is updated,
// then the radix-2 divider turns out the quotient one bit per cycle, and then
// the output register is loaded, held off for as long as the previous result
// still waits there. The input is ready again the cycle after the load, so a
// sample is only accepted once the previous one has been loaded. A new sample
// is accepted while the previous result still waits in the output register.
// The store needs no clearing pass after reset.
module windowed_moving_average import wma_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [SMP_W-1:0] sample,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [AVG_W-1:0] average
);

	cmd_t cmd;
	sts_t sts;

	// Sequence each beat
	wma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Store, sum and divide
	wma_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.sample  (sample),
		.average (average)
	);

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the windowed moving average block.
`timescale 1ns / 1ps

module tb_top import wma_pkg::*; ();

	localparam int RUN_LIMIT = 500_000;
	localparam int HOLD_LEN  = 400;
	localparam int SETTLE    = 40;
	localparam int PHASE_LEN = 340;
	localparam int RUN_LEN   = WINDOW + 10;
	localparam int N_ROWS    = 20;

	typedef struct packed {
		logic [SMP_W-1:0] smp;
		logic             pinned;
		logic [AVG_W-1:0] avg;
	} directed_row_t;

	// Opening rows: full scale, zero, single bits, patterns. Pinned rows carry
	// an average worked out by hand; the rest go through the predictor.
	directed_row_t directed_rows [N_ROWS] = '{
		'{16'hFFFF, 1'b1, 16'hFFFF},
		'{16'h0000, 1'b1, 16'h7FFF},
		'{16'h0001, 1'b1, 16'h5555},
		'{16'h0000, 1'b1, 16'h4000},
		'{16'h8000, 1'b0, 16'h0000},
		'{16'h7FFF, 1'b0, 16'h0000},
		'{16'h00FF, 1'b0, 16'h0000},
		'{16'hFF00, 1'b0, 16'h0000},
		'{16'h0100, 1'b0, 16'h0000},
		'{16'hAAAA, 1'b0, 16'h0000},
		'{16'h5555, 1'b0, 16'h0000},
		'{16'h0080, 1'b0, 16'h0000},
		'{16'hFFFE, 1'b0, 16'h0000},
		'{16'h0002, 1'b0, 16'h0000},
		'{16'hF0F0, 1'b0, 16'h0000},
		'{16'h0F0F, 1'b0, 16'h0000},
		'{16'hFFFF, 1'b0, 16'h0000},
		'{16'hFFFF, 1'b0, 16'h0000},
		'{16'h0000, 1'b0, 16'h0000},
		'{16'h1234, 1'b0, 16'h0000}
	};

	logic             clk            = 1'b0;
	logic             arst_n         = 1'b0;
	logic             in_valid       = 1'b0;
	logic             in_ready;
	logic [SMP_W-1:0] sample         = '0;
	logic             out_valid;
	logic             out_ready      = 1'b0;
	logic [AVG_W-1:0] average;

	// Side-band of the sample beat: a hand-worked average to check instead
	logic             sample_pinned  = 1'b0;
	logic [AVG_W-1:0] pinned_average = '0;

	// Window state as the block should hold it
	logic [SMP_W-1:0] window_store [WINDOW];
	logic [SUM_W-1:0] window_sum    = '0;
	logic [PTR_W-1:0] window_wr_idx = '0;
	logic [CNT_W-1:0] window_fill   = '0;

	logic [AVG_W-1:0] pending_averages [$];
	int unsigned      mismatch_count  = 0;
	int unsigned      cycle_count     = 0;
	int unsigned      send_idle_pct   = 0;
	int unsigned      recv_idle_pct   = 0;
	int unsigned      recv_hold_left  = 0;
	logic             recv_hold_start = 1'b0;

	windowed_moving_average i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.average   (average)
	);

	always #1 clk = ~clk;

	// Take one sample into the window and return the truncated mean
	function automatic logic [AVG_W-1:0] next_average(input logic [SMP_W-1:0] s);
		logic [SUM_W-1:0] quotient;
		if (window_fill == CNT_W'(WINDOW))
			window_sum = window_sum - SUM_W'(window_store[window_wr_idx]);
		else
			window_fill = window_fill + 1'b1;
		window_store[window_wr_idx] = s;
		window_sum = window_sum + SUM_W'(s);
		window_wr_idx = (window_wr_idx == PTR_W'(WINDOW - 1)) ? '0 : window_wr_idx + 1'b1;
		quotient = window_sum / SUM_W'(window_fill);
		return quotient[AVG_W-1:0];
	endfunction

	// Random sample, biased toward the ends of the range and single bits
	function automatic logic [SMP_W-1:0] pick_sample();
		int unsigned kind;
		int unsigned bit_pos;
		kind    = $urandom_range(9);
		bit_pos = $urandom_range(SMP_W - 1);
		case (kind)
			4: return '1;
			5: return '0;
			6: return SMP_W'($urandom_range(255));
			7: return SMP_W'(1) << bit_pos;
			8: return ~(SMP_W'(1) << bit_pos);
			9: return SMP_W'($urandom_range(65535, 65000));
			default: return SMP_W'($urandom);
		endcase
	endfunction

	// Offer one sample beat, with random gaps ahead of it, until accepted
	task automatic send_sample(input logic [SMP_W-1:0] s, input logic pin,
			input logic [AVG_W-1:0] pin_avg);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		sample         <= s;
		sample_pinned  <= pin;
		pinned_average <= pin_avg;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering and hold until every average has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_averages.size() != 0);
	endtask

	// Predict on each accepted sample beat, check each accepted average beat
	always @(posedge clk) begin : watch_beats
		logic [AVG_W-1:0] predicted;
		logic [AVG_W-1:0] oldest;
		if (arst_n && in_valid && in_ready) begin
			predicted = next_average(sample);
			pending_averages.push_back(sample_pinned ? pinned_average : predicted);
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_averages.size() == 0) begin
				$error("average: no beat expected, actual %h", average);
				mismatch_count++;
			end else begin
				oldest = pending_averages.pop_front();
				if (average !== oldest) begin
					$error("average: expected %h, actual %h", oldest, average);
					mismatch_count++;
				end
			end
		end
	end

	// Drive ready: a requested long hold-off first, random stalls otherwise
	always @(posedge clk) begin
		if (recv_hold_start) begin
			recv_hold_left  = HOLD_LEN;
			recv_hold_start = 1'b0;
		end
		if (recv_hold_left > 0) begin
			recv_hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("FAIL windowed_moving_average");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening, warm-up from an empty window
		send_idle_pct = 23;
		recv_idle_pct = 80;
		foreach (directed_rows[i])
			send_sample(directed_rows[i].smp, directed_rows[i].pinned, directed_rows[i].avg);
		drain_results();

		// Random phases: sender-light idling, receiver-light idling, then none
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 80 : 0;
			recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 23 : 0;
			for (int i = 0; i < PHASE_LEN; i++) begin
				// Back up the output while samples keep coming
				if (phase == 2 && i == 100)
					recv_hold_start = 1'b1;
				// Pause the sender until the block is empty
				if (phase == 1 && i == 200)
					drain_results();
				// Full window of full-scale samples, then of zeros
				if (i == 150)
					for (int k = 0; k < RUN_LEN; k++)
						send_sample('1, 1'b0, '0);
				if (i == 300)
					for (int k = 0; k < RUN_LEN; k++)
						send_sample('0, 1'b0, '0);
				send_sample(pick_sample(), 1'b0, '0);
			end
			drain_results();
		end

		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS windowed_moving_average");
		else
			$display("FAIL windowed_moving_average");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/wma_pkg.sv
src/wma_ram.sv
src/wma_ctrl.sv
src/wma_dp.sv
src/windowed_moving_average.sv
dv/tb_top.sv
